[hdl/isc_pkg.sv]
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the interval split cost engine
// Holds the fixed payload widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Fixed payload widths.
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned COST_OUT_W = 44;

  typedef logic [ELEM_W-1:0]     elem_t;
  typedef logic [COST_OUT_W-1:0] cost_out_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_LOAD = 9'b000000001,
    ST_DIAG = 9'b000000010,
    ST_RD   = 9'b000000100,
    ST_WIN  = 9'b000001000,
    ST_CRD  = 9'b000010000,
    ST_CMP  = 9'b000100000,
    ST_WR   = 9'b001000000,
    ST_OUT  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

endpackage

[hdl/isc_if.sv]
// ----------------------------------------------------------------------------
// isc_if: element and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface isc_in_if;
  logic          valid;
  logic          ready;
  isc_pkg::elem_t elem_value;
  logic          is_last;

  modport source (output valid, output elem_value, output is_last, input ready);
  modport sink   (input valid, input elem_value, input is_last, output ready);
endinterface

interface isc_out_if;
  logic               valid;
  logic               ready;
  isc_pkg::cost_out_t total_cost;
  logic               overflow;

  modport source (output valid, output total_cost, output overflow, input ready);
  modport sink   (input valid, input total_cost, input overflow, output ready);
endinterface

[hdl/interval_split_cost_dp_core.sv]
// ----------------------------------------------------------------------------
// interval_split_cost_dp_core: Knuth-windowed interval split cost engine
// Loads a sequence of elements, fills the interval cost table with a single
// shared add/compare unit and returns the cost of the whole sequence.
// ----------------------------------------------------------------------------
// Elements arrive on in_ch one beat per cycle while loading and are folded
// into a running prefix sum that is written to the prefix store; elements
// past MAX_LEN are dropped and flagged. The beat with is_last closes the
// sequence (even when it is itself dropped), and in_ch.ready then stays low
// while the tables are filled. The fill writes the diagonal, then for every
// longer interval reads the neighboring splits, tries each split of its Knuth
// window and writes the best; last it fetches the whole-sequence cost. Each
// split candidate needs one two-port read of the cost table and one pass
// through the shared adder and comparator; the window sum over all intervals
// grows with n squared. The result beat is held in an output register, so
// loading of the next sequence starts while an unread result still waits
// on out_ch; a new result waits for that one. The cost and split tables are
// not cleared: every entry is written by the fill before it is read. Reported
// costs are the exact cost modulo 2^44.
// ----------------------------------------------------------------------------
module interval_split_cost_dp_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  isc_in_if.sink    in_ch,
  isc_out_if.source out_ch
);

  // Index width covers 0..MAX_LEN; sums and costs grow with it.
  localparam int unsigned IW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = isc_pkg::ELEM_W + IW;
  localparam int unsigned CW = isc_pkg::ELEM_W + 2 * IW;
  localparam int unsigned AW = 2 * IW;

  localparam logic [IW-1:0] ONE   = IW'(1);
  localparam logic [IW-1:0] TWO   = IW'(2);
  localparam logic [IW-1:0] MAX_N = IW'(MAX_LEN);

  // Memories: prefix sums indexed by position, and the two interval tables
  // indexed by {left, right}.
  logic [PW-1:0] prefix_mem [2**IW];
  logic [CW-1:0] cost_mem   [2**AW];
  logic [IW-1:0] split_mem  [2**AW];

  isc_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] n_r, n_nxt;          // kept element count
  logic          ovf_r, ovf_nxt;      // an element was dropped
  logic [PW-1:0] run_sum_r, run_sum_nxt;
  logic [IW-1:0] len_r, len_nxt;
  logic [IW-1:0] l_r, l_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [PW-1:0] sum_r, sum_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [IW-1:0] bestk_r, bestk_nxt;
  logic          found_r, found_nxt;

  logic                  out_valid_r, out_valid_nxt;
  isc_pkg::cost_out_t    out_cost_r, out_cost_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Registered read data.
  logic [PW-1:0] pa_r, pb_r;
  logic [CW-1:0] ca_r, cb_r;
  logic [IW-1:0] sa_r, sb_r;

  logic          in_beat;
  logic [IW-1:0] r_w, rm1_w, lp1_w, lm1_w, kp1_w;
  logic [AW-1:0] cost_ra, cost_rb, cost_wa;
  logic          cost_we;
  logic [CW-1:0] cost_wd;
  logic [IW-1:0] split_wd;
  logic [PW-1:0] win_sum;
  logic [IW-1:0] win_lo, win_hi;
  logic [CW-1:0] cand;

  assign in_beat = in_ch.valid && in_ch.ready;

  assign r_w   = IW'(l_r + len_r - ONE);
  assign rm1_w = r_w - ONE;
  assign lp1_w = l_r + ONE;
  assign lm1_w = l_r - ONE;
  assign kp1_w = k_r + ONE;

  assign cost_ra  = (state_r == isc_pkg::ST_CRD) ? {l_r, k_r} : {ONE, n_r};
  assign cost_rb  = {kp1_w, r_w};
  assign cost_we  = (state_r == isc_pkg::ST_DIAG) || (state_r == isc_pkg::ST_WR);
  assign cost_wa  = (state_r == isc_pkg::ST_DIAG) ? {l_r, l_r} : {l_r, r_w};
  assign cost_wd  = (state_r == isc_pkg::ST_DIAG) ? '0 : best_r;
  assign split_wd = (state_r == isc_pkg::ST_DIAG) ? l_r : bestk_r;

  // Prefix store: one write port fed by the load, two read ports.
  always_ff @(posedge clk) begin
    if (in_beat && (n_r < MAX_N)) begin
      prefix_mem[n_r + ONE] <= run_sum_r + PW'(in_ch.elem_value);
    end
    pa_r <= prefix_mem[r_w];
    pb_r <= prefix_mem[lm1_w];
  end

  // Cost and split tables: written by the fill, two read ports each.
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa]  <= cost_wd;
      split_mem[cost_wa] <= split_wd;
    end
    ca_r <= cost_mem[cost_ra];
    cb_r <= cost_mem[cost_rb];
    sa_r <= split_mem[{l_r, rm1_w}];
    sb_r <= split_mem[{lp1_w, r_w}];
  end

  // Knuth window from the neighboring splits, clamped to [l, r-1]; a reversed
  // window falls back to the full range. Prefix entry zero is taken as zero.
  always_comb begin
    win_lo = sa_r;
    win_hi = sb_r;
    if (win_lo > win_hi) begin
      win_lo = l_r;
      win_hi = rm1_w;
    end
    if (win_lo < l_r) begin
      win_lo = l_r;
    end
    if (win_hi > rm1_w) begin
      win_hi = rm1_w;
    end
    win_sum = pa_r - ((l_r == ONE) ? '0 : pb_r);
  end

  // The shared unit: one candidate cost per pass.
  assign cand = ca_r + cb_r + CW'(sum_r);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    run_sum_nxt   = run_sum_r;
    len_nxt       = len_r;
    l_nxt         = l_r;
    k_nxt         = k_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    bestk_nxt     = bestk_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cost_nxt  = out_cost_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      isc_pkg::ST_LOAD: begin
        if (in_beat) begin
          if (n_r < MAX_N) begin
            n_nxt       = n_r + ONE;
            run_sum_nxt = run_sum_r + PW'(in_ch.elem_value);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            l_nxt     = ONE;
            state_nxt = isc_pkg::ST_DIAG;
          end
        end
      end
      isc_pkg::ST_DIAG: begin
        if (l_r == n_r) begin
          if (n_r == ONE) begin
            state_nxt = isc_pkg::ST_OUT;
          end else begin
            len_nxt   = TWO;
            l_nxt     = ONE;
            state_nxt = isc_pkg::ST_RD;
          end
        end else begin
          l_nxt = lp1_w;
        end
      end
      isc_pkg::ST_RD: begin
        state_nxt = isc_pkg::ST_WIN;
      end
      isc_pkg::ST_WIN: begin
        sum_nxt   = win_sum;
        bestk_nxt = l_r;
        found_nxt = 1'b0;
        if (win_lo > win_hi) begin
          best_nxt  = CW'(win_sum);
          state_nxt = isc_pkg::ST_WR;
        end else begin
          k_nxt     = win_lo;
          hi_nxt    = win_hi;
          state_nxt = isc_pkg::ST_CRD;
        end
      end
      isc_pkg::ST_CRD: begin
        state_nxt = isc_pkg::ST_CMP;
      end
      isc_pkg::ST_CMP: begin
        // Strict compare keeps the first split on ties.
        if (!found_r || (cand < best_r)) begin
          best_nxt  = cand;
          bestk_nxt = k_r;
          found_nxt = 1'b1;
        end
        if (k_r == hi_r) begin
          state_nxt = isc_pkg::ST_WR;
        end else begin
          k_nxt     = kp1_w;
          state_nxt = isc_pkg::ST_CRD;
        end
      end
      isc_pkg::ST_WR: begin
        if (r_w == n_r) begin
          if (len_r == n_r) begin
            state_nxt = isc_pkg::ST_OUT;
          end else begin
            len_nxt   = len_r + ONE;
            l_nxt     = ONE;
            state_nxt = isc_pkg::ST_RD;
          end
        end else begin
          l_nxt     = lp1_w;
          state_nxt = isc_pkg::ST_RD;
        end
      end
      isc_pkg::ST_OUT: begin
        state_nxt = isc_pkg::ST_FIN;
      end
      isc_pkg::ST_FIN: begin
        // Cost of the whole sequence sits on read port A; wait for room.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = isc_pkg::COST_OUT_W'(ca_r);
          out_ovf_nxt   = ovf_r;
          n_nxt         = '0;
          ovf_nxt       = 1'b0;
          run_sum_nxt   = '0;
          state_nxt     = isc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = isc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isc_pkg::ST_LOAD;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      run_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      ovf_r       <= ovf_nxt;
      run_sum_r   <= run_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    l_r        <= l_nxt;
    k_r        <= k_nxt;
    hi_r       <= hi_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    bestk_r    <= bestk_nxt;
    found_r    <= found_nxt;
    out_cost_r <= out_cost_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_ch.ready       = (state_r == isc_pkg::ST_LOAD);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.total_cost = out_cost_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

[hdl/isc_chk.sv]
// ----------------------------------------------------------------------------
// isc_chk: port-level checks for the interval split cost engine
// Watches both channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module isc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_ready,
  input isc_pkg::cost_out_t out_total_cost,
  input logic               out_overflow
);

  // A result beat that is not taken holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_cost) &&
      $stable(out_overflow))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The closing element starts the fill, so the input stops taking beats.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input still ready after the closing element");

  // A new result only appears at the end of a fill.
  a_result_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while loading");

  // Loading resumes together with the posting of a result.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid)
    else $error("input ready again without a result");

endmodule

bind interval_split_cost_dp_core isc_chk u_isc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_is_last     (in_ch.is_last),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_total_cost (out_ch.total_cost),
  .out_overflow   (out_ch.overflow)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interval split cost engine
// Feeds element sequences through the valid/ready input channel, predicts
// the whole-sequence split cost of each one and checks every result beat.
// ----------------------------------------------------------------------------
module tb_top;

  // Sequence capacity of the engine under test. The predictor below uses the
  // same figure, so both drop elements past it in the same way.
  localparam int unsigned SEQ_CAP = 64;

  // Length of the long output hold-off used to back the engine up.
  localparam int unsigned HOLD_CYCLES = 2000;

  // One expected result beat.
  typedef struct packed {
    isc_pkg::cost_out_t total_cost;
    logic               overflow;
  } cost_result_t;

  // Value patterns for random element content. Tiny values give many equal
  // costs and so exercise the lowest-split tie rule.
  typedef enum int unsigned {
    MIX_FULL,
    MIX_TINY,
    MIX_EDGE,
    MIX_MODEST
  } value_mix_t;

  logic clk;
  logic rst_n;

  isc_in_if  in_ch ();
  isc_out_if out_ch ();

  interval_split_cost_dp_core #(
    .MAX_LEN(SEQ_CAP)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: running prefix sums of the open sequence, the interval
  // cost and best-split tables, and the kept-count and dropped flags.
  // Costs are kept in 64 bits; for 64 elements of 32 bits they stay exact.
  // --------------------------------------------------------------------------
  longint unsigned run_sum   [0:SEQ_CAP];
  longint unsigned span_cost [1:SEQ_CAP][1:SEQ_CAP];
  int unsigned     best_cut  [1:SEQ_CAP+1][1:SEQ_CAP];
  int unsigned     kept_elems;
  logic            elems_dropped;

  // Results predicted but not yet seen on the output channel, oldest first.
  cost_result_t pending_costs[$];

  // Traffic shaping, written by the test tasks and read by the drivers.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned hold_left;

  // Run bookkeeping.
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_sent;
  int unsigned seqs_sent;
  int unsigned overlong_seqs;
  int unsigned longest_seq;

  // --------------------------------------------------------------------------
  // Clock and run limit. The limit sits far above the slowest legal run,
  // which is dominated by the few full-length table fills.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still pending.", pending_costs.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Minimum split cost of elements 1..n, shortest intervals first. The split
  // search for [l..r] runs over the Knuth window taken from the two shorter
  // neighbors; a reversed window opens up to the full range, and the window
  // is clamped to [l, r-1]. A strict compare keeps the lowest split on ties.
  // --------------------------------------------------------------------------
  function automatic longint unsigned interval_cost(input int unsigned n);
    int unsigned     r;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     best_k;
    longint unsigned seg_sum;
    longint unsigned best;
    longint unsigned cand;
    if (n == 0) return 0;
    for (int unsigned i = 1; i <= n; i++) begin
      span_cost[i][i] = 0;
      best_cut[i][i]  = i;
    end
    for (int unsigned len = 2; len <= n; len++) begin
      for (int unsigned l = 1; l + len - 1 <= n; l++) begin
        r       = l + len - 1;
        lo      = best_cut[l][r-1];
        hi      = best_cut[l+1][r];
        seg_sum = run_sum[r] - run_sum[l-1];
        best    = 64'hFFFF_FFFF_FFFF_FFFF;
        best_k  = l;
        if (lo > hi) begin
          lo = l;
          hi = r - 1;
        end
        if (lo < l) lo = l;
        if (hi > r - 1) hi = r - 1;
        for (int unsigned k = lo; k <= hi; k++) begin
          cand = span_cost[l][k] + span_cost[k+1][r] + seg_sum;
          if (cand < best) begin
            best   = cand;
            best_k = k;
          end
        end
        if (best == 64'hFFFF_FFFF_FFFF_FFFF) best = seg_sum;
        span_cost[l][r] = best;
        best_cut[l][r]  = best_k;
      end
    end
    return span_cost[1][n];
  endfunction

  function automatic isc_pkg::elem_t rand_elem(input value_mix_t mix);
    case (mix)
      MIX_FULL: return isc_pkg::elem_t'($urandom());
      MIX_TINY: return isc_pkg::elem_t'($urandom_range(3));
      MIX_EDGE: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return {1'b1, 31'($urandom())};
        endcase
      end
      default: return isc_pkg::elem_t'($urandom_range(1000));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sends one element beat. Random idle cycles come first; valid then stays
  // high until the beat is taken. The ready value read right after the edge
  // is the one the engine saw at that edge, so acceptance is exact. The
  // predictor is advanced at the accepting edge. Valid is left high so that
  // a following beat can go out in the next cycle with no gap.
  // --------------------------------------------------------------------------
  task automatic send_elem(input isc_pkg::elem_t value, input logic last);
    cost_result_t res;
    longint unsigned full_cost;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.elem_value <= value;
    in_ch.is_last    <= last;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (kept_elems < SEQ_CAP) begin
      run_sum[kept_elems+1] = run_sum[kept_elems] + longint'(value);
      kept_elems++;
    end else begin
      elems_dropped = 1'b1;
    end
    // The end mark closes the sequence even when its own value was dropped.
    if (last) begin
      full_cost      = interval_cost(kept_elems);
      res.total_cost = isc_pkg::cost_out_t'(full_cost);
      res.overflow   = elems_dropped;
      pending_costs.push_back(res);
      kept_elems    = 0;
      elems_dropped = 1'b0;
      run_sum[0]    = 0;
    end
  endtask

  task automatic send_seq(input isc_pkg::elem_t vals[$]);
    foreach (vals[i]) send_elem(vals[i], i == vals.size() - 1);
    seqs_sent++;
    if (vals.size() > SEQ_CAP) overlong_seqs++;
    if (vals.size() > longest_seq) longest_seq = vals.size();
  endtask

  // Drops valid and waits until every predicted result has been checked.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_costs.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready follows the stall mix, and is held low for a counted
  // stretch when a hold-off is requested.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req)  hold_left <= HOLD_CYCLES;
    out_ch.ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    cost_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_costs.size() == 0) begin
        $error("result beat with nothing pending: total_cost=%0d overflow=%0b",
               out_ch.total_cost, out_ch.overflow);
        mismatches++;
      end else begin
        want = pending_costs.pop_front();
        results_seen++;
        if (out_ch.total_cost !== want.total_cost) begin
          $error("total_cost: expected %0d, actual %0d", want.total_cost, out_ch.total_cost);
          mismatches++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner sequences with no idling: single elements at both extremes, the
  // largest pair, all-zero and all-equal runs for ties, an ascending run and mixed extremes.
  task automatic test_directed_corners();
    isc_pkg::elem_t s[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    s = '{32'd0};
    send_seq(s);
    s = '{32'hFFFF_FFFF};
    send_seq(s);
    s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_seq(s);
    s = '{32'd0, 32'd0, 32'd0};
    send_seq(s);
    s = '{32'd1, 32'd2, 32'd3, 32'd4};
    send_seq(s);
    s = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    send_seq(s);
    s = '{32'd5, 32'd5, 32'd5, 32'd5, 32'd5};
    send_seq(s);
    s = '{32'h8000_0000, 32'd1, 32'h7FFF_FFFF};
    send_seq(s);
    wait_drain();
  endtask

  // A full-length run of maximum values gives the widest cost the engine can
  // report. A run two past capacity then has its end mark dropped, and a
  // short run after it shows the counters and the dropped flag were cleared.
  task automatic test_wide_and_overflow();
    isc_pkg::elem_t s[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    s.delete();
    repeat (SEQ_CAP) s.push_back('1);
    send_seq(s);
    s.delete();
    repeat (SEQ_CAP + 2) s.push_back(rand_elem(MIX_FULL));
    send_seq(s);
    s = '{32'd7, 32'd9};
    send_seq(s);
    wait_drain();
  endtask

  // The output is held off for a long counted stretch while short sequences
  // keep coming: one result parks in the output register, the next fill
  // completes and waits, and the input then stalls until the hold ends.
  task automatic test_backpressure_fill();
    isc_pkg::elem_t s[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    wait (hold_left != 0);
    hold_req = 1'b0;
    repeat (4) begin
      s.delete();
      repeat (3) s.push_back(rand_elem(MIX_MODEST));
      send_seq(s);
    end
    wait_drain();
  endtask

  // Random sequences, mostly short to keep the table fills cheap, with a few
  // long ones and now and then one past capacity.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_beats);
    int unsigned    sent;
    int unsigned    len;
    int unsigned    pick;
    value_mix_t     mix;
    isc_pkg::elem_t s[$];
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(24, 9);
      else if (pick < 99) len = $urandom_range(SEQ_CAP, 25);
      else                len = $urandom_range(SEQ_CAP + 6, SEQ_CAP + 1);
      mix = value_mix_t'($urandom_range(3));
      s.delete();
      repeat (len) s.push_back(rand_elem(mix));
      send_seq(s);
      sent += len;
    end
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.elem_value <= '0;
    in_ch.is_last    <= 1'b0;
    rst_n            <= 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    kept_elems     = 0;
    elems_dropped  = 1'b0;
    run_sum[0]     = 0;
    beats_sent     = 0;
    seqs_sent      = 0;
    overlong_seqs  = 0;
    longest_seq    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_wide_and_overflow();
    test_backpressure_fill();
    test_random_traffic(0, 0, 215);
    test_random_traffic(61, 0, 215);
    test_random_traffic(0, 61, 215);
    test_random_traffic(16, 16, 215);

    // Let any stray result beat show up before the verdict.
    in_ch.valid <= 1'b0;
    repeat (200) @(posedge clk);

    $display("Sent %0d element beats in %0d sequences (%0d past capacity, longest %0d).",
             beats_sent, seqs_sent, overlong_seqs, longest_seq);
    $display("Checked %0d results under idle, stall and %0d-cycle hold-off traffic.",
             results_seen, HOLD_CYCLES);
    if (mismatches == 0 && pending_costs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
